### hdl/window_mean_stddev_core_macros.svh
// Assertion macros shared by the window mean / deviation core.
`ifndef WINDOW_MEAN_STDDEV_CORE_MACROS_SVH
`define WINDOW_MEAN_STDDEV_CORE_MACROS_SVH

// cond in one cycle implies prop in the next cycle
`define WMS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

// cond implies prop in the same cycle
`define WMS_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

### hdl/wms_pkg.sv
// Types and constants shared by the window mean / deviation core.
`timescale 1ns / 1ps

package wms_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mean;
        logic [SAMPLE_BITS-1:0] deviation;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic wr_sample;   // write accepted sample into window
        logic scan_start;  // start a pass over the window
        logic scan_sq;     // pass accumulates squared differences (else plain sum)
        logic div_start;   // divide accumulator by constant
        logic div_sel_var; // divisor is depth - 1 (else depth)
        logic mean_load;   // latch quotient as mean
        logic root_start;  // start floor root of quotient
        logic out_load;    // load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_busy;
        logic div_busy;
        logic root_busy;
        logic out_free;
    } t_status;

endpackage

### hdl/window_mean_stddev_core.sv
// Top level of the moving window mean and sample standard deviation core.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_stall   | i_in  (op, sample)
//   out     | output    | o_out_valid / i_out_stall | o_out (mean, deviation)
//
// A sample transaction writes the window memory directly.
// A tick walks the window twice through the one-read memory port, divides twice
// by reciprocal multiply, runs the bit-serial root once and loads the result.
// Reset is synchronous; per-entry valid bits make the window read as zero at once.
// A result waits in the output register under stall; samples are still taken then.
`timescale 1ns / 1ps

module window_mean_stddev_core #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  wms_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output wms_pkg::t_out o_out
);

    wms_pkg::t_cmd    cmd;
    wms_pkg::t_status status;

    wms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in.op),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wms_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

### hdl/wms_datapath.sv
// Datapath: window memory, scan/accumulate pipeline, reciprocal divider, serial root, result register.
`timescale 1ns / 1ps

module wms_datapath #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wms_pkg::t_cmd   i_cmd,
    output wms_pkg::t_status o_status,
    input  wms_pkg::t_in    i_in,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output wms_pkg::t_out   o_out
);

    localparam int SB     = wms_pkg::SAMPLE_BITS;
    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int SQ_W   = 2 * SB + $clog2(WINDOW_DEPTH);
    localparam int ROOT_W = (SQ_W + 1) / 2;
    localparam int RCNT_W = $clog2(ROOT_W + 1);
    localparam int RS     = SQ_W + IDX_W;
    localparam int RCP_W  = SQ_W + 2;
    localparam int PROD_W = SQ_W + RCP_W;

    localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [SQ_W-1:0]   BIT_INIT     = SQ_W'(1) << (2 * (ROOT_W - 1));
    // ceil(2^RS / d): exact quotient for any dividend below 2^SQ_W since d <= 2^IDX_W
    localparam logic [RCP_W-1:0]  RCP_MEAN     =
        RCP_W'(((64'd1 << RS) + 64'(WINDOW_DEPTH - 1)) / 64'(WINDOW_DEPTH));
    localparam logic [RCP_W-1:0]  RCP_VAR      =
        RCP_W'(((64'd1 << RS) + 64'(WINDOW_DEPTH - 2)) / 64'(WINDOW_DEPTH - 1));

    // window store; valid bits stand in for the cleared contents after reset
    logic [SB-1:0]           mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_valid;
    logic [IDX_W-1:0]        r_wr_idx;
    logic [IDX_W-1:0]        n_wr_idx;

    // scan pipeline
    logic [IDX_W-1:0] r_addr;
    logic             r_issue;
    logic             r_p1;
    logic             r_p2;
    logic             r_sq_mode;
    logic [SB-1:0]    r_rd;
    logic             r_rd_vld;
    logic [SQ_W-1:0]  r_term;
    logic [SQ_W-1:0]  r_acc;
    logic [SB-1:0]    r_mean;

    logic [SB-1:0]    entry;
    logic [SB-1:0]    diff;
    logic [2*SB-1:0]  diff_sq;

    // divider
    logic [RCP_W-1:0]  recip;
    logic [PROD_W-1:0] r_prod;
    logic              r_div_busy;
    logic [SQ_W-1:0]   r_quo;

    // root
    logic [SQ_W-1:0]   r_rv;
    logic [SQ_W-1:0]   r_res;
    logic [SQ_W-1:0]   r_bit;
    logic [RCNT_W-1:0] r_rcnt;
    logic [SQ_W:0]     root_t;
    logic              root_ge;

    logic              r_out_vld;
    wms_pkg::t_out     r_out;
    logic [SB-1:0]     dev_sat;

    // ---------------- window write ----------------
    assign n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_valid  <= '0;
        end else if (i_cmd.wr_sample) begin
            r_wr_idx          <= n_wr_idx;
            r_valid[n_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sample) begin
            mem[n_wr_idx] <= i_in.sample;
        end
        r_rd <= mem[r_addr];
    end

    // ---------------- scan / accumulate ----------------
    assign entry   = r_rd_vld ? r_rd : '0;
    assign diff    = (entry > r_mean) ? (entry - r_mean) : (r_mean - entry);
    assign diff_sq = diff * diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_p1    <= 1'b0;
            r_p2    <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_issue <= 1'b1;
            end else if (r_issue && r_addr == LAST_IDX) begin
                r_issue <= 1'b0;
            end
            r_p1 <= r_issue;
            r_p2 <= r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_addr    <= '0;
            r_sq_mode <= i_cmd.scan_sq;
            r_acc     <= '0;
        end else begin
            if (r_issue) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            if (r_p2) begin
                r_acc <= r_acc + r_term;
            end
        end
        r_rd_vld <= r_valid[r_addr];
        r_term   <= r_sq_mode ? SQ_W'(diff_sq) : SQ_W'(entry);
        if (i_cmd.mean_load) begin
            r_mean <= r_quo[SB-1:0];
        end
    end

    // ---------------- constant divide: multiply by reciprocal, then shift ----------------
    assign recip = i_cmd.div_sel_var ? RCP_VAR : RCP_MEAN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else begin
            r_div_busy <= i_cmd.div_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_prod <= PROD_W'(r_acc) * PROD_W'(recip);
        end
        if (r_div_busy) begin
            r_quo <= SQ_W'(r_prod[PROD_W-1:RS]);
        end
    end

    // ---------------- floor root, one result bit a cycle ----------------
    assign root_t  = {1'b0, r_res} + {1'b0, r_bit};
    assign root_ge = ({1'b0, r_rv} >= root_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcnt <= '0;
        end else if (i_cmd.root_start) begin
            r_rcnt <= RCNT_W'(ROOT_W);
        end else if (r_rcnt != '0) begin
            r_rcnt <= r_rcnt - RCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_start) begin
            r_rv  <= r_quo;
            r_res <= '0;
            r_bit <= BIT_INIT;
        end else if (r_rcnt != '0) begin
            if (root_ge) begin
                r_rv  <= r_rv - root_t[SQ_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // ---------------- result register ----------------
    assign dev_sat = (r_res[ROOT_W-1:0] > ROOT_W'(wms_pkg::SAMPLE_MAX)) ?
                     wms_pkg::SAMPLE_MAX : r_res[SB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.mean      <= r_mean;
            r_out.deviation <= dev_sat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assign o_status.scan_busy = r_issue | r_p1 | r_p2;
    assign o_status.div_busy  = r_div_busy;
    assign o_status.root_busy = (r_rcnt != '0);
    assign o_status.out_free  = !r_out_vld || !i_out_stall;

endmodule

### hdl/wms_ctrl.sv
// Controller: sequences sum pass, mean divide, square pass, variance divide, root, result load.
`timescale 1ns / 1ps
`include "window_mean_stddev_core_macros.svh"

module wms_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    output logic             o_in_stall,
    input  wms_pkg::t_status i_status,
    output wms_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_DIVM = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_DIVS = 3'd4;
    localparam logic [2:0] ST_ROOT = 3'd5;
    localparam logic [2:0] ST_OUTW = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_op == wms_pkg::OP_TICK) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SUM;
                    end else begin
                        o_cmd.wr_sample = 1'b1;
                    end
                end
            end
            ST_SUM: begin
                if (!i_status.scan_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIVM;
                end
            end
            ST_DIVM: begin
                if (!i_status.div_busy) begin
                    o_cmd.mean_load  = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_sq    = 1'b1;
                    n_state          = ST_SQ;
                end
            end
            ST_SQ: begin
                if (!i_status.scan_busy) begin
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel_var = 1'b1;
                    n_state           = ST_DIVS;
                end
            end
            ST_DIVS: begin
                if (!i_status.div_busy) begin
                    o_cmd.root_start = 1'b1;
                    n_state          = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (!i_status.root_busy) begin
                    n_state = ST_OUTW;
                end
            end
            ST_OUTW: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `WMS_ASSERT_NOW(a_scan_start_idle, o_cmd.scan_start, !i_status.scan_busy, "scan restarted while busy")
    `WMS_ASSERT_NEXT(a_scan_runs, o_cmd.scan_start, i_status.scan_busy, "scan did not start")
    `WMS_ASSERT_NEXT(a_div_runs, o_cmd.div_start, i_status.div_busy, "divider did not start")
    `WMS_ASSERT_NOW(a_out_free, o_cmd.out_load, i_status.out_free, "result overwrote pending output")

endmodule
